/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MBRW_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("mbrw assertion failed");
`define MBRW_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mbrw implication failed");
`define MBRW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mbrw next-cycle check failed");
`else
`define MBRW_ASSERT(label, clk, rst, prop)
`define MBRW_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MBRW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/mbrw_pkg.sv */
// types, constants and codes for the msb-first bit reader and writer
`default_nettype none
package mbrw_pkg;

  localparam int BUFFER_BYTES   = 4096;
  localparam int ADDR_W         = $clog2(BUFFER_BYTES);
  localparam int SIZE_W         = 13;
  localparam int MAX_READ_BITS  = 32;
  localparam int MAX_WRITE_BITS = 64;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

  typedef enum logic [2:0] {
    OP_STORE   = 3'd0,
    OP_FETCH   = 3'd1,
    OP_RESTART = 3'd2,
    OP_READ    = 3'd3,
    OP_WRITE   = 3'd4,
    OP_SKIP    = 3'd5
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FETCH_WAIT,
    S_RD_STEP,
    S_RD_WAIT,
    S_WR_STEP,
    S_WR_WAIT,
    S_WR_TAKE,
    S_SKIP_WAIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [11:0] byte_address;
    logic [7:0]  store_data;
    logic [6:0]  bit_count;
    logic [63:0] field_value;
    logic [12:0] skip_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] field_out;
    logic [7:0]  fetched_byte;
    logic [15:0] bits_left;
    logic        overrun;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic check;
    logic host_write;
    logic host_read;
    logic fetch_capture;
    logic restart;
    logic rd_load;
    logic rd_enter;
    logic rd_take;
    logic wr_new;
    logic wr_load;
    logic wr_enter;
    logic wr_take;
    logic skip_adv;
    logic skip_reload;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       over_now;
    logic       n_zero;
    logic       bic_zero;
    logic       skip_zero;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

/* hw/rtl/mbrw_datapath.sv */
// datapath: byte buffer, bit cursor, field assembly and result register
`default_nettype none
`include "assert_macros.svh"
module mbrw_datapath import mbrw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  in_item_t          in_item,
  input  logic              cfg_write_en,
  input  logic [SIZE_W-1:0] cfg_write_data,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item
);

  logic [7:0] mem [BUFFER_BYTES];
  logic [7:0] rd_data;

  logic [SIZE_W-1:0] buffer_size;
  logic [SIZE_W-1:0] cursor_byte;
  logic [3:0]        bits_in_current;
  logic [7:0]        current_shift;

  logic [2:0]        op;
  logic [ADDR_W-1:0] addr;
  logic [7:0]        sdata;
  logic [6:0]        n;
  logic [63:0]       aligned;
  logic [SIZE_W-1:0] skip;
  logic [31:0]       acc;
  logic [7:0]        fetched;
  logic              over;
  logic [7:0]        wbyte;

  logic [SIZE_W-1:0] eff_size;
  logic              beyond;
  logic [SIZE_W-1:0] room;
  logic [15:0]       avail;
  logic              over_now;
  logic [3:0]        take;
  logic [7:0]        rd_bits;
  logic [31:0]       acc_next;
  logic [7:0]        wr_chunk;
  logic [7:0]        wr_byte;
  logic [SIZE_W-1:0] cursor_m1;
  logic [SIZE_W-1:0] skip_end;
  logic [SIZE_W-1:0] skip_end_m1;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  always_comb begin
    eff_size    = (buffer_size > SIZE_W'(BUFFER_BYTES)) ? SIZE_W'(BUFFER_BYTES) : buffer_size;
    beyond      = cursor_byte > eff_size;
    room        = eff_size - cursor_byte;
    avail       = beyond ? 16'd0 : ({room, 3'b000} + 16'(bits_in_current));
    take        = (n < 7'(bits_in_current)) ? n[3:0] : bits_in_current;
    rd_bits     = current_shift >> (4'd8 - take);
    acc_next    = (acc << take) | 32'(rd_bits);
    wr_chunk    = aligned[63:56] >> (4'd8 - take);
    wr_byte     = wbyte | 8'(wr_chunk << (bits_in_current - take));
    cursor_m1   = cursor_byte - SIZE_W'(1);
    skip_end    = cursor_byte + skip;
    skip_end_m1 = skip_end - SIZE_W'(1);
    over_now    = 1'b0;
    case (op)
      OP_READ:  over_now = (n > 7'(MAX_READ_BITS)) || (16'(n) > avail);
      OP_WRITE: over_now = (n > 7'(MAX_WRITE_BITS)) || (16'(n) > avail);
      OP_SKIP:  over_now = beyond || (skip > room);
      default:  over_now = 1'b0;
    endcase
  end

  // buffer ports: one read address and one write address
  always_comb begin
    rd_en   = cmd.host_read || cmd.rd_load || cmd.wr_load || cmd.skip_adv;
    rd_addr = addr;
    if (cmd.rd_load) begin
      rd_addr = cursor_byte[ADDR_W-1:0];
    end else if (cmd.wr_load) begin
      rd_addr = cursor_m1[ADDR_W-1:0];
    end else if (cmd.skip_adv) begin
      rd_addr = skip_end_m1[ADDR_W-1:0];
    end
    wr_en   = cmd.host_write || cmd.wr_take;
    wr_addr = cmd.wr_take ? cursor_m1[ADDR_W-1:0] : addr;
    wr_data = cmd.wr_take ? wr_byte : sdata;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size     <= SIZE_RESET;
      cursor_byte     <= '0;
      bits_in_current <= '0;
      current_shift   <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        buffer_size <= cfg_write_data;
      end
      if (cmd.restart) begin
        cursor_byte     <= '0;
        bits_in_current <= '0;
        current_shift   <= '0;
      end
      if (cmd.rd_enter) begin
        cursor_byte     <= cursor_byte + SIZE_W'(1);
        bits_in_current <= 4'd8;
        current_shift   <= rd_data;
      end
      if (cmd.rd_take) begin
        current_shift   <= current_shift << take;
        bits_in_current <= bits_in_current - take;
      end
      if (cmd.wr_new) begin
        cursor_byte     <= cursor_byte + SIZE_W'(1);
        bits_in_current <= 4'd8;
      end
      if (cmd.wr_take) begin
        bits_in_current <= bits_in_current - take;
      end
      if (cmd.skip_adv) begin
        cursor_byte <= skip_end;
      end
      if (cmd.skip_reload) begin
        current_shift <= rd_data << (4'd8 - bits_in_current);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op      <= in_item.opcode;
      addr    <= in_item.byte_address;
      sdata   <= in_item.store_data;
      n       <= in_item.bit_count;
      aligned <= in_item.field_value << (7'd64 - in_item.bit_count);
      skip    <= in_item.skip_count;
      acc     <= '0;
      fetched <= '0;
      over    <= 1'b0;
    end
    if (cmd.check) begin
      over <= over_now;
    end
    if (cmd.fetch_capture) begin
      fetched <= rd_data;
    end
    if (cmd.rd_take) begin
      acc <= acc_next;
      n   <= n - 7'(take);
    end
    if (cmd.wr_new) begin
      wbyte <= '0;
    end
    if (cmd.wr_enter) begin
      wbyte <= rd_data;
    end
    if (cmd.wr_take) begin
      aligned <= aligned << take;
      n       <= n - 7'(take);
    end
    if (cmd.out_load) begin
      out_item.field_out    <= acc;
      out_item.fetched_byte <= fetched;
      out_item.bits_left    <= avail;
      out_item.overrun      <= over;
    end
  end

  always_comb begin
    sts.opcode    = op;
    sts.over_now  = over_now;
    sts.n_zero    = (n == 7'd0);
    sts.bic_zero  = (bits_in_current == 4'd0);
    sts.skip_zero = (skip == '0);
    sts.out_free  = !out_valid || out_ready;
  end

  `MBRW_ASSERT(a_bic_range, clk, rst, bits_in_current <= 4'd8)
  `MBRW_ASSERT_IMPL(a_take_live, clk, rst, cmd.rd_take || cmd.wr_take, !sts.bic_zero && !sts.n_zero)
  `MBRW_ASSERT_IMPL(a_load_free, clk, rst, cmd.out_load, sts.out_free)

endmodule
`default_nettype wire

/* hw/rtl/mbrw_ctrl.sv */
// controller state machine sequencing one item through the datapath
`default_nettype none
`include "assert_macros.svh"
module mbrw_ctrl import mbrw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.check  = 1'b1;
        state_next = S_RESP;
        unique case (sts.opcode)
          OP_STORE: begin
            cmd.host_write = 1'b1;
          end
          OP_FETCH: begin
            cmd.host_read = 1'b1;
            state_next    = S_FETCH_WAIT;
          end
          OP_RESTART: begin
            cmd.restart = 1'b1;
          end
          OP_READ: begin
            if (!sts.over_now) begin
              state_next = S_RD_STEP;
            end
          end
          OP_WRITE: begin
            if (!sts.over_now) begin
              state_next = S_WR_STEP;
            end
          end
          OP_SKIP: begin
            if (!sts.over_now && !sts.skip_zero) begin
              cmd.skip_adv = 1'b1;
              if (!sts.bic_zero) begin
                state_next = S_SKIP_WAIT;
              end
            end
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end
      S_FETCH_WAIT: begin
        cmd.fetch_capture = 1'b1;
        state_next        = S_RESP;
      end
      S_RD_STEP: begin
        if (sts.n_zero) begin
          state_next = S_RESP;
        end else if (sts.bic_zero) begin
          cmd.rd_load = 1'b1;
          state_next  = S_RD_WAIT;
        end else begin
          cmd.rd_take = 1'b1;
        end
      end
      S_RD_WAIT: begin
        cmd.rd_enter = 1'b1;
        state_next   = S_RD_STEP;
      end
      S_WR_STEP: begin
        if (sts.n_zero) begin
          state_next = S_RESP;
        end else if (sts.bic_zero) begin
          cmd.wr_new = 1'b1;
          state_next = S_WR_TAKE;
        end else begin
          cmd.wr_load = 1'b1;
          state_next  = S_WR_WAIT;
        end
      end
      S_WR_WAIT: begin
        cmd.wr_enter = 1'b1;
        state_next   = S_WR_TAKE;
      end
      S_WR_TAKE: begin
        cmd.wr_take = 1'b1;
        state_next  = S_WR_STEP;
      end
      S_SKIP_WAIT: begin
        cmd.skip_reload = 1'b1;
        state_next      = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `MBRW_ASSERT_NEXT(a_resp_stall, clk, rst, state == S_RESP && !sts.out_free, state == S_RESP)
  `MBRW_ASSERT_IMPL(a_rd_wait_src, clk, rst, state == S_RD_WAIT, $past(state) == S_RD_STEP)

endmodule
`default_nettype wire

/* hw/rtl/msb_first_bit_reader_writer_top.sv */
// top level of the msb-first bit field reader and writer
//
// input channel in_valid/in_ready carries one item (opcode, address, data,
// field width, field value, skip count); output channel out_valid/out_ready
// returns exactly one result item per input item, in order.
// buffer_size is written through cfg_write_en/cfg_write_data; the user must
// do so only while idle, which the block itself does not enforce.
// one item is in flight at a time; the input is taken again once the result
// is in the output register, so the next item runs while that result waits.
// each byte a read's cursor enters is fetched through the registered buffer
// read before its bits are taken; a write reads back a partly used byte
// through that read before merging into it, and starts an entered byte empty.
// fetch and skip with reload also wait on the registered read.
// with a ready receiver the next item is taken at the same edge as the result.
// a stalled receiver holds the block in its result step; nothing is lost.
// synchronous reset clears the cursor, sets buffer_size to 4096 and empties
// the output; buffer contents are not cleared and must be stored before use.
`default_nettype none
module msb_first_bit_reader_writer_top import mbrw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item,
  input  logic              cfg_write_en,
  input  logic [SIZE_W-1:0] cfg_write_data
);

  cmd_t cmd;
  sts_t sts;

  mbrw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mbrw_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .in_item        (in_item),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item)
  );

endmodule
`default_nettype wire
